/* sv/glos_pkg.sv */
// Shared types and constants of the grid line-of-sight block.
// Depends on nothing; imported by the top level.
`default_nettype none

package glos_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned ROW_W  = 7;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned CELL_W = 4;

  // Reset value of the closed threshold.
  localparam logic [CELL_W-1:0] THR_RESET = 4'd12;

  // Item opcodes.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

endpackage : glos_pkg

`default_nettype wire

/* sv/glos_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies; used by the top level for the cell map.
`default_nettype none

module glos_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule : glos_ram

`default_nettype wire

/* sv/grid_line_of_sight_top.sv */
// Top level of the grid line-of-sight block: map storage and line walker.
// Depends on glos_pkg and glos_ram.
`default_nettype none

// Channel     Direction  Handshake                Payload
// ---------   ---------  -----------------------  ---------------------------------------
// item        in         start_i high, busy_o low opcode, from/to row and column, cell value
// result      out        done_o strobe, 1 cycle   visible_o
// threshold   in         cfg_we_i high            cfg_wdata_i
//
// A write transaction is stored in the cycle it is accepted; busy_o stays low, so
// writes can arrive in every cycle. A query whose axis distances are both below two
// keeps busy_o high only through set-up. Otherwise the walk reads one map cell per cycle
// from the single RAM port until it reaches the end cell or a walked cell blocks
// sight. The result strobe comes in the first cycle with busy_o low, and a new
// transaction may be accepted in that cycle.
// Reset is asynchronous and active low; it clears the control state and sets the
// threshold to twelve. The map contents are undefined until written. The receiver
// cannot stall results.

module grid_line_of_sight_top #(
  parameter int unsigned ROW_BITS = 7,
  parameter int unsigned COL_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        opcode_i,
  input  logic [ROW_BITS-1:0]         from_row_i,
  input  logic [COL_BITS-1:0]         from_col_i,
  input  logic [ROW_BITS-1:0]         to_row_i,
  input  logic [COL_BITS-1:0]         to_col_i,
  input  logic [glos_pkg::CELL_W-1:0] cell_value_i,
  input  logic                        cfg_we_i,
  input  logic [glos_pkg::CELL_W-1:0] cfg_wdata_i,
  output logic                        done_o,
  output logic                        visible_o
);

  import glos_pkg::*;

  localparam int unsigned ADDR_W = ROW_BITS + COL_BITS;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned MAX_W  = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
  // The error term stays within a few times the larger distance, so three
  // guard bits beyond the coordinate width rule out any overflow.
  localparam int unsigned ERR_W  = MAX_W + 3;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CELL_W-1:0]   thr_q;
  logic                done_q, done_d;
  logic                visible_q, visible_d;

  // Walk registers: current position, end position, distances, directions, error.
  logic [COL_BITS-1:0] x_q, x_d, c1_q, c1_d;
  logic [ROW_BITS-1:0] y_q, y_d, r1_q, r1_d;
  logic [COL_BITS-1:0] dx_q, dx_d;
  logic [ROW_BITS-1:0] dy_q, dy_d;
  logic                sxn_q, sxn_d, syn_q, syn_d;
  logic signed [ERR_W-1:0] err_q, err_d;

  logic                accept;
  logic                wr_item;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [CELL_W-1:0]   ram_rdata;

  // Combinational step of the walk.
  logic signed [ERR_W-1:0] dx_s, dy_s, err_n;
  logic                move_x, move_y;
  logic [COL_BITS-1:0] x_n;
  logic [ROW_BITS-1:0] y_n;
  logic                at_end;
  logic                blocked;

  // Set-up values derived from the latched start and end cells.
  logic                su_xpos, su_ypos;
  logic [COL_BITS-1:0] su_dx;
  logic [ROW_BITS-1:0] su_dy;

  assign accept  = start_i && (state_q == S_IDLE);
  assign wr_item = accept && (opcode_e'(opcode_i) == OP_WRITE);
  assign busy_o  = (state_q != S_IDLE);

  // Distances and directions, computed once per query.
  assign su_xpos = (x_q < c1_q);
  assign su_ypos = (y_q < r1_q);
  assign su_dx   = su_xpos ? (c1_q - x_q) : (x_q - c1_q);
  assign su_dy   = su_ypos ? (r1_q - y_q) : (y_q - r1_q);

  // One Bresenham step from the current position.
  assign dx_s   = signed'(ERR_W'(dx_q));
  assign dy_s   = signed'(ERR_W'(dy_q));
  assign move_x = (err_q > -dx_s);
  assign move_y = (err_q < dy_s);
  assign err_n  = err_q - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
  assign x_n    = move_x ? (sxn_q ? x_q - 1'b1 : x_q + 1'b1) : x_q;
  assign y_n    = move_y ? (syn_q ? y_q - 1'b1 : y_q + 1'b1) : y_q;
  assign at_end = (x_n == c1_q) && (y_n == r1_q);

  // The cell read in the previous cycle blocks sight when its kind reaches the threshold.
  assign blocked = (ram_rdata >= thr_q);

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    visible_d = visible_q;
    x_d       = x_q;
    y_d       = y_q;
    c1_d      = c1_q;
    r1_d      = r1_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    sxn_d     = sxn_q;
    syn_d     = syn_q;
    err_d     = err_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (opcode_e'(opcode_i) == OP_QUERY)) begin
          x_d     = from_col_i;
          y_d     = from_row_i;
          c1_d    = to_col_i;
          r1_d    = to_row_i;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        dx_d  = su_dx;
        dy_d  = su_dy;
        sxn_d = !su_xpos;
        syn_d = !su_ypos;
        // Half of dx, or minus half of dy, truncated toward zero.
        if (MAX_W'(su_dx) > MAX_W'(su_dy)) begin
          err_d = signed'(ERR_W'(su_dx >> 1));
        end else begin
          err_d = -signed'(ERR_W'(su_dy >> 1));
        end
        if ((su_dx < COL_BITS'(2)) && (su_dy < ROW_BITS'(2))) begin
          done_d    = 1'b1;
          visible_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_STEP;
        end
      end
      S_STEP, S_CHECK: begin
        if ((state_q == S_CHECK) && blocked) begin
          done_d    = 1'b1;
          visible_d = 1'b0;
          state_d   = S_IDLE;
        end else if (at_end) begin
          done_d    = 1'b1;
          visible_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          x_d     = x_n;
          y_d     = y_n;
          err_d   = err_n;
          state_d = S_CHECK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The map port writes a cell for a write transaction, and otherwise reads the
  // next cell of the walk. Writes happen only while idle, so they never overlap a read.
  assign ram_we   = wr_item;
  assign ram_addr = wr_item ? {from_row_i, from_col_i} : {y_n, x_n};

  glos_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (cell_value_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      thr_q   <= THR_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    visible_q <= visible_d;
    x_q       <= x_d;
    y_q       <= y_d;
    c1_q      <= c1_d;
    r1_q      <= r1_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    sxn_q     <= sxn_d;
    syn_q     <= syn_d;
    err_q     <= err_d;
  end

  assign done_o    = done_q;
  assign visible_o = visible_q;

`ifndef NO_ASSERTIONS
  // A result is only ever produced by a query that was in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q != S_IDLE))
    else $error("result strobe without a query in progress");

  // The map is never written while a walk is reading it.
  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE))
    else $error("map write during a walk");

  // The end cell is never read as an obstacle.
  a_end_not_tested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> !((x_q == c1_q) && (y_q == r1_q)))
    else $error("end cell tested during a walk");

  // An accepted query always proceeds to set-up.
  a_query_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i) |=> (state_q == S_SETUP))
    else $error("accepted query did not start");
`endif

endmodule : grid_line_of_sight_top

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for grid_line_of_sight_top: map writes and line-of-sight queries.
// It depends on glos_pkg and on the block's RTL. An internal predictor supplies the
// expected visibility result of every query whose table row does not give one.
`timescale 1ns / 100ps

module tb_top;
  import glos_pkg::*;

  localparam int MAP_CELLS = 1 << (ROW_W + COL_W);
  localparam int ROW_MAX   = (1 << ROW_W) - 1;
  localparam int COL_MAX   = (1 << COL_W) - 1;
  localparam int PHASES    = 6;
  localparam int ITEMS     = 1700;

  // Every input is given a known value from time zero onwards.
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start_i      = 1'b0;
  logic                opcode_i     = OP_WRITE;
  logic [ROW_W-1:0]    from_row_i   = '0;
  logic [COL_W-1:0]    from_col_i   = '0;
  logic [ROW_W-1:0]    to_row_i     = '0;
  logic [COL_W-1:0]    to_col_i     = '0;
  logic [CELL_W-1:0]   cell_value_i = '0;
  logic                cfg_we_i     = 1'b0;
  logic [CELL_W-1:0]   cfg_wdata_i  = '0;
  logic                busy_o;
  logic                done_o;
  logic                visible_o;

  grid_line_of_sight_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .from_row_i   (from_row_i),
    .from_col_i   (from_col_i),
    .to_row_i     (to_row_i),
    .to_col_i     (to_col_i),
    .cell_value_i (cell_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .visible_o    (visible_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: our own copy of the map, a record of which cells have been
  // written, and the current closed threshold.
  logic [CELL_W-1:0] kind_map   [MAP_CELLS];
  bit                kind_known [MAP_CELLS];
  logic [CELL_W-1:0] closed_thr = THR_RESET;

  bit sight_q [$];   // visibility results still owed by the block, oldest first
  int fill_q  [$];   // cells on a line that must be written before it is queried
  int fails   = 0;
  int sent    = 0;      // transactions accepted by the block so far
  bit steady  = 1'b0;   // when set, the sender never idles
  int hot_row = 0;
  int hot_col = 0;

  // One row of the directed table. A threshold row carries the new value in val.
  typedef struct packed {
    bit                cfg;
    opcode_e           op;
    logic [ROW_W-1:0]  fr;
    logic [COL_W-1:0]  fc;
    logic [ROW_W-1:0]  tr;
    logic [COL_W-1:0]  tc;
    logic [CELL_W-1:0] val;
    bit                typed;
    bit                vis;
  } dir_row_t;

  // Hand-written cases: the no-walk shortcut, the corners of the grid, blocking just
  // at and just below the threshold, a diagonal, steep and long lines (the long
  // ones stress the width of the error term), a zero threshold that blocks every
  // tested cell, and the top threshold. Cells that a row relies on are written
  // beforehand by the row itself.
  dir_row_t plan [24] = '{
    '{1'b0, OP_QUERY,   0,   0,   1,   1,  0, 1'b1, 1'b1},
    '{1'b0, OP_QUERY, 127, 255, 126, 254,  0, 1'b1, 1'b1},
    '{1'b0, OP_QUERY,   5,   7,   5,   7,  0, 1'b1, 1'b1},
    '{1'b0, OP_WRITE,   0,   1,   0,   0, 15, 1'b0, 1'b0},
    '{1'b0, OP_QUERY,   0,   0,   0,   3,  0, 1'b1, 1'b0},
    '{1'b0, OP_WRITE, 127, 254,   0,   0,  0, 1'b0, 1'b0},
    '{1'b0, OP_QUERY, 127, 255, 127, 253,  0, 1'b1, 1'b1},
    '{1'b0, OP_WRITE,  64, 128,   0,   0, 11, 1'b0, 1'b0},
    '{1'b0, OP_QUERY,  64, 127,  64, 129,  0, 1'b1, 1'b1},
    '{1'b0, OP_WRITE,  64, 128,   0,   0, 12, 1'b0, 1'b0},
    '{1'b0, OP_QUERY,  64, 127,  64, 129,  0, 1'b1, 1'b0},
    '{1'b0, OP_WRITE,   1,   1,   0,   0,  3, 1'b0, 1'b0},
    '{1'b0, OP_QUERY,   0,   0,   2,   2,  0, 1'b1, 1'b1},
    '{1'b0, OP_QUERY,  20,   5,   2,   9,  0, 1'b0, 1'b0},
    '{1'b0, OP_QUERY,   0,   0, 127, 255,  0, 1'b0, 1'b0},
    '{1'b0, OP_QUERY, 127, 255,   0,   0,  0, 1'b0, 1'b0},
    '{1'b0, OP_QUERY,   0, 255, 127,   0,  0, 1'b0, 1'b0},
    '{1'b1, OP_WRITE,   0,   0,   0,   0,  0, 1'b0, 1'b0},
    '{1'b0, OP_WRITE,  10,  10,   0,   0,  0, 1'b0, 1'b0},
    '{1'b0, OP_QUERY,  10,   9,  10,  11,  0, 1'b1, 1'b0},
    '{1'b0, OP_QUERY,   0,   0,   1,   0,  0, 1'b1, 1'b1},
    '{1'b1, OP_WRITE,   0,   0,   0,   0, 15, 1'b0, 1'b0},
    '{1'b0, OP_QUERY,   0,   0,   0,   3,  0, 1'b1, 1'b0},
    '{1'b0, OP_QUERY,  64, 127,  64, 129,  0, 1'b1, 1'b1}
  };

  function automatic int cell_at(int r, int c);
    return (r << COL_W) | c;
  endfunction

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Mostly open ground with the occasional wall, so that walks run a fair way.
  function automatic logic [CELL_W-1:0] terrain_kind();
    if ($urandom_range(0, 99) < 95) return CELL_W'($urandom_range(0, 7));
    return CELL_W'($urandom_range(8, 15));
  endfunction

  // Bresenham walk from (r0,c0) to (r1,c1). In normal use it returns the visibility
  // of the end cell. With gather set it only lists the unwritten cells strictly
  // between the ends in fill_q, and never stops at a wall.
  function automatic bit line_visible(int r0, int c0, int r1, int c1, bit gather);
    int sx, sy, dx, dy, err, e2, x, y, n;
    sx = (c0 < c1) ? 1 : -1;
    sy = (r0 < r1) ? 1 : -1;
    dx = (sx > 0) ? (c1 - c0) : (c0 - c1);
    dy = (sy > 0) ? (r1 - r0) : (r0 - r1);
    x  = c0;
    y  = r0;
    if (dx < 2 && dy < 2) return 1'b1;
    // SystemVerilog integer division truncates toward zero, as required here.
    err = (dx > dy ? dx : -dy) / 2;
    for (n = 0; n < 1024; n++) begin
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x   += sx;
      end
      if (e2 < dy) begin
        err += dx;
        y   += sy;
      end
      if (x == c1 && y == r1) return 1'b1;
      if (gather) begin
        if (!kind_known[cell_at(y, x)]) fill_q.push_back(cell_at(y, x));
      end else if (kind_map[cell_at(y, x)] >= closed_thr) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Offers one transaction and holds it until the block takes it. While the block
  // is busy the start line is dropped at random too, so that the sender's gaps fall
  // on every phase of a walk. The start line is left high on return: whatever comes
  // next either drives the following transaction or lowers it in the same step.
  task automatic send_item(opcode_e op, int fr, int fc, int tr, int tc,
                           logic [CELL_W-1:0] val, bit typed, bit typed_vis);
    bit accepted;
    accepted     = 1'b0;
    start_i      <= steady || ($urandom_range(0, 99) >= 34);
    opcode_i     <= op;
    from_row_i   <= ROW_W'(fr);
    from_col_i   <= COL_W'(fc);
    to_row_i     <= ROW_W'(tr);
    to_col_i     <= COL_W'(tc);
    cell_value_i <= val;
    while (!accepted) begin
      @(posedge clk_i);
      if (start_i && !busy_o) accepted = 1'b1;
      else start_i <= steady || ($urandom_range(0, 99) >= 34);
    end
    sent++;
    if (op == OP_WRITE) begin
      kind_map[cell_at(fr, fc)]   = val;
      kind_known[cell_at(fr, fc)] = 1'b1;
    end else begin
      sight_q.push_back(typed ? typed_vis : line_visible(fr, fc, tr, tc, 1'b0));
    end
  endtask

  // Issues a query, first writing any cell on its line that has never been written,
  // the two end cells included, so that the block never reads an undefined entry.
  task automatic send_query(int fr, int fc, int tr, int tc, bit typed, bit typed_vis);
    int a;
    fill_q.delete();
    fill_q.push_back(cell_at(fr, fc));
    fill_q.push_back(cell_at(tr, tc));
    void'(line_visible(fr, fc, tr, tc, 1'b1));
    while (fill_q.size() != 0) begin
      a = fill_q.pop_front();
      if (!kind_known[a])
        send_item(OP_WRITE, a >> COL_W, a % (1 << COL_W), $urandom_range(0, ROW_MAX),
                  $urandom_range(0, COL_MAX), terrain_kind(), 1'b0, 1'b0);
    end
    hot_row = fr;
    hot_col = fc;
    send_item(OP_QUERY, fr, fc, tr, tc, CELL_W'($urandom_range(0, 15)), typed, typed_vis);
  endtask

  // Stops sending and waits, within a bound, for every owed result. The extra cycles
  // afterwards let the block settle, since a write produces no result.
  task automatic drain_results();
    int waited;
    waited  = 0;
    start_i <= 1'b0;
    while (sight_q.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (16) @(posedge clk_i);
    if (sight_q.size() != 0) begin
      $error("%0d visibility results never arrived", sight_q.size());
      fails++;
      sight_q.delete();
    end
  endtask

  // The threshold is only changed while the block is idle.
  task automatic set_threshold(logic [CELL_W-1:0] thr);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    closed_thr  = thr;
  endtask

  // One random transaction: a quarter are writes (half of them near the last query
  // start, so that they land on lines about to be walked), the rest are queries of
  // mostly modest length, with a few no-walk queries and a few spanning the grid.
  task automatic random_transaction();
    int pick, fr, fc, tr, tc, span;
    pick = $urandom_range(0, 99);
    fr   = $urandom_range(0, ROW_MAX);
    fc   = $urandom_range(0, COL_MAX);
    if (pick < 25) begin
      if (pick < 12) begin
        fr = clip(hot_row + $urandom_range(0, 12) - 6, ROW_MAX);
        fc = clip(hot_col + $urandom_range(0, 12) - 6, COL_MAX);
      end
      send_item(OP_WRITE, fr, fc, $urandom_range(0, ROW_MAX), $urandom_range(0, COL_MAX),
                CELL_W'($urandom_range(0, 15)), 1'b0, 1'b0);
    end else begin
      if (pick < 31) span = 1;
      else if (pick < 35) span = COL_MAX;
      else span = $urandom_range(2, 24);
      tr = clip(fr + $urandom_range(0, 2 * span) - span, ROW_MAX);
      tc = clip(fc + $urandom_range(0, 2 * span) - span, COL_MAX);
      send_query(fr, fc, tr, tc, 1'b0, 1'b0);
    end
    if ($urandom_range(0, 99) == 0) drain_results();
  endtask

  // Result checker: each strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    bit want;
    if (rst_ni && done_o === 1'b1) begin
      if (sight_q.size() == 0) begin
        $error("visible: no result expected, got %0b", visible_o);
        fails++;
      end else begin
        want = sight_q.pop_front();
        if (visible_o !== want) begin
          $error("visible: expected %0b, got %0b", want, visible_o);
          fails++;
        end
      end
    end
  end

  // Main sequence: reset, the directed table, then random phases under a range of
  // thresholds, each phase beginning from an idle block. The transactions left over
  // after the directed table, fill writes included, are shared out over the phases.
  initial begin : stimulus
    logic [CELL_W-1:0] thr_plan [PHASES];
    int ph;
    int base;
    int quota;
    thr_plan = '{4'd15, 4'd0, 4'd12, CELL_W'($urandom_range(2, 14)), 4'd1,
                 CELL_W'($urandom_range(0, 15))};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg)
        set_threshold(plan[i].val);
      else if (plan[i].op == OP_QUERY)
        send_query(plan[i].fr, plan[i].fc, plan[i].tr, plan[i].tc, plan[i].typed, plan[i].vis);
      else
        send_item(OP_WRITE, plan[i].fr, plan[i].fc, plan[i].tr, plan[i].tc, plan[i].val,
                  1'b0, 1'b0);
    end

    base  = sent;
    quota = (ITEMS > base) ? (ITEMS - base) / PHASES : 1;

    // The third phase runs flat out, with the sender never idling.
    for (ph = 0; ph < PHASES; ph++) begin
      steady = (ph == 2);
      set_threshold(thr_plan[ph]);
      while (sent < base + (ph + 1) * quota) random_transaction();
    end

    drain_results();
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
